[rtl/joystick_event_detector_defines.svh]
// assertion macros shared by the joystick event detector rtl
// no dependencies; included by modules that carry assertions
`ifndef JOYSTICK_EVENT_DETECTOR_DEFINES_SVH
`define JOYSTICK_EVENT_DETECTOR_DEFINES_SVH

// property checked at every clock edge outside reset
`define JED_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define JED_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/jed_pkg.sv]
// joystick event detector package: sizes, field layout, register indexes, types
// no dependencies
package jed_pkg;

   localparam int NUM_BUTTONS  = 32;
   localparam int SAMPLE_BITS  = 16;
   localparam int NUM_AXES     = 8;
   localparam int HAT_BITS     = 17;
   localparam int BUTTON_BITS  = 32;
   localparam int EVENT_BITS   = 43;
   localparam int THR_BITS     = 15;
   localparam int CHAN_BITS    = 9;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_BITS     = 32;

   localparam int POV_CHAN     = 8;
   localparam int SLIDER_FIRST = 6;

   localparam int NUM_SLOTS     = NUM_AXES + 2 + NUM_BUTTONS;
   localparam int SLOT_IDX_BITS = $clog2(NUM_SLOTS + 1);
   localparam int CMP_BITS      = (SAMPLE_BITS + 2 > THR_BITS) ? SAMPLE_BITS + 2 : THR_BITS;

   localparam int HAT_LSB      = NUM_AXES * SAMPLE_BITS;
   localparam int BUTTON_LSB   = HAT_LSB + HAT_BITS;
   localparam int IN_FIELDS    = BUTTON_LSB + BUTTON_BITS;
   localparam int IN_DATA_BITS = ((IN_FIELDS + 7) / 8) * 8;
   localparam int OUT_DATA_BITS = ((EVENT_BITS + 7) / 8) * 8;

   localparam logic [CSR_IDX_BITS-1:0] REG_ENABLED_CHANNELS  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_RELATIVE_CHANNELS = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_ENABLED_BUTTONS   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_LEVEL_THRESHOLD   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_CHANGE_THRESHOLD  = 3'd4;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [THR_BITS-1:0]           thr_type;
   typedef logic [EVENT_BITS-1:0]         events_type;
   typedef logic [NUM_SLOTS-1:0]          slots_type;

   localparam sample_type SLIDER_REST = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   localparam logic [CHAN_BITS-1:0]   ENABLED_CHANNELS_RST  = 9'd3;
   localparam logic [CHAN_BITS-1:0]   RELATIVE_CHANNELS_RST = 9'd448;
   localparam logic [BUTTON_BITS-1:0] ENABLED_BUTTONS_RST   = 32'd1;
   localparam thr_type                LEVEL_THRESHOLD_RST   = 15'd16384;
   localparam thr_type                CHANGE_THRESHOLD_RST  = 15'd3277;

   typedef struct packed {
      logic      attached;
      slots_type hit;
      slots_type mask;
   } frame_type;

endpackage

[rtl/jed_axis_lane.sv]
// one axis lane: level test on the sample or change test against the stored previous sample
// depends on jed_pkg
module jed_axis_lane (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                relative,
   input  jed_pkg::sample_type sample,
   input  jed_pkg::sample_type init,
   input  jed_pkg::thr_type    level_thr,
   input  jed_pkg::thr_type    change_thr,
   output logic                hit
);
   import jed_pkg::*;

   sample_type               prev_ff;
   sample_type               prev_in;
   logic [SAMPLE_BITS+1:0]   ext_v;
   logic [SAMPLE_BITS+1:0]   ext_p;
   logic [SAMPLE_BITS+1:0]   diff;
   logic [SAMPLE_BITS+1:0]   abs_v;
   logic [SAMPLE_BITS+1:0]   abs_d;

   always_comb begin
      ext_v = {{2{sample[SAMPLE_BITS-1]}}, sample};
      ext_p = {{2{prev_ff[SAMPLE_BITS-1]}}, prev_ff};
      diff  = ext_v - ext_p;
      abs_v = ext_v[SAMPLE_BITS+1] ? -ext_v : ext_v;
      abs_d = diff[SAMPLE_BITS+1] ? -diff : diff;
      if (relative) begin
         hit = CMP_BITS'(abs_d) > CMP_BITS'(change_thr);
      end else begin
         hit = CMP_BITS'(abs_v) > CMP_BITS'(level_thr);
      end
      prev_in = load ? sample : prev_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= init;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

[rtl/jed_pack.sv]
// merging stage: packs lane hits densely behind the idle bit, output register
// depends on jed_pkg and joystick_event_detector_defines.svh
module jed_pack (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                load_valid,
   input  jed_pkg::frame_type  frame,
   output logic                valid,
   output jed_pkg::events_type events,
   output logic                not_attached
);
   import jed_pkg::*;
   `include "joystick_event_detector_defines.svh"

   logic                     valid_ff;
   logic                     valid_in;
   events_type               events_ff;
   events_type               events_in;
   logic                     not_attached_ff;
   logic                     not_attached_in;
   slots_type                fired;
   events_type               packed_ev;
   logic [SLOT_IDX_BITS-1:0] pos;

   always_comb begin
      fired     = frame.hit & frame.mask;
      packed_ev = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         pos = SLOT_IDX_BITS'($countones(frame.mask & ((NUM_SLOTS'(1) << i) - NUM_SLOTS'(1))));
         packed_ev = packed_ev | (EVENT_BITS'(fired[i]) << (pos + SLOT_IDX_BITS'(1)));
      end
      packed_ev[0] = ~|fired;
      valid_in        = load ? load_valid : valid_ff;
      events_in       = events_ff;
      not_attached_in = not_attached_ff;
      if (load) begin
         events_in       = frame.attached ? packed_ev : '0;
         not_attached_in = ~frame.attached;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      events_ff       <= events_in;
      not_attached_ff <= not_attached_in;
   end

   assign valid        = valid_ff;
   assign events       = events_ff;
   assign not_attached = not_attached_ff;

   `JED_ASSERT(a_detached_no_events, clock, reset, valid_ff && not_attached_ff |-> events_ff == '0, "detached request carries events")
   `JED_ASSERT(a_attached_nonzero, clock, reset, valid_ff && !not_attached_ff |-> events_ff != '0, "attached request has neither idle nor event")
   `JED_ASSERT(a_idle_alone, clock, reset, valid_ff && events_ff[0] |-> events_ff[EVENT_BITS-1:1] == '0, "idle bit set together with events")

endmodule

[rtl/joystick_event_detector.sv]
// path: an accepted request is held in the stage-one frame register, then in the jed_pack output register
// throughput: one request per cycle while rsp is not stalled; the lane compares and the packing network
// each feed their own register, and previous samples update at the edge that accepts an attached request
// reset: synchronous, active high; clears valids, loads register defaults,
// previous axes to zero (sliders to most negative) and previous hat to centered
module joystick_event_detector (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pos_x, pos_y, pos_z, turn_x, turn_y, turn_z, slider_one, slider_two,
   // hat_angle, button_bits, zero fill
   input  logic [jed_pkg::IN_DATA_BITS-1:0]   req_tdata,
   // attached
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // events, zero fill
   output logic [jed_pkg::OUT_DATA_BITS-1:0]  rsp_tdata,
   // not_attached
   output logic                               rsp_tuser,
   input  logic                               csr_we,
   input  logic [jed_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [jed_pkg::CSR_BITS-1:0]       csr_wdata
);
   import jed_pkg::*;
   `include "joystick_event_detector_defines.svh"

   logic [CHAN_BITS-1:0]      en_chan_ff;
   logic [CHAN_BITS-1:0]      en_chan_in;
   logic [CHAN_BITS-1:0]      rel_chan_ff;
   logic [CHAN_BITS-1:0]      rel_chan_in;
   logic [BUTTON_BITS-1:0]    en_btn_ff;
   logic [BUTTON_BITS-1:0]    en_btn_in;
   thr_type                   level_thr_ff;
   thr_type                   level_thr_in;
   thr_type                   change_thr_ff;
   thr_type                   change_thr_in;

   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   frame_type                 s1_frame_ff;
   frame_type                 s1_frame_in;
   logic [HAT_BITS-1:0]       prev_hat_ff;
   logic [HAT_BITS-1:0]       prev_hat_in;

   logic                      out_valid;
   logic                      en2;
   logic                      en1;
   logic                      accept;
   logic                      update;
   logic [NUM_AXES-1:0]       axis_hit;
   logic [HAT_BITS-1:0]       hat;
   logic [BUTTON_BITS-1:0]    buttons;
   logic                      hat_fire;
   events_type                events;
   logic                      not_attached;

   always_comb begin
      en_chan_in    = en_chan_ff;
      rel_chan_in   = rel_chan_ff;
      en_btn_in     = en_btn_ff;
      level_thr_in  = level_thr_ff;
      change_thr_in = change_thr_ff;
      if (csr_we) begin
         case (csr_index)
            REG_ENABLED_CHANNELS:  en_chan_in    = csr_wdata[CHAN_BITS-1:0];
            REG_RELATIVE_CHANNELS: rel_chan_in   = csr_wdata[CHAN_BITS-1:0];
            REG_ENABLED_BUTTONS:   en_btn_in     = csr_wdata[BUTTON_BITS-1:0];
            REG_LEVEL_THRESHOLD:   level_thr_in  = csr_wdata[THR_BITS-1:0];
            REG_CHANGE_THRESHOLD:  change_thr_in = csr_wdata[THR_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign en2        = ~out_valid | rsp_tready;
   assign en1        = ~s1_valid_ff | en2;
   assign req_tready = en1;
   assign accept     = req_tvalid & en1;
   assign update     = accept & req_tuser;
   assign hat        = req_tdata[HAT_LSB +: HAT_BITS];
   assign buttons    = req_tdata[BUTTON_LSB +: BUTTON_BITS];

   for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
      jed_axis_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .load       (update),
         .relative   (rel_chan_ff[g]),
         .sample     (req_tdata[g*SAMPLE_BITS +: SAMPLE_BITS]),
         .init       ((g >= SLIDER_FIRST) ? SLIDER_REST : sample_type'(0)),
         .level_thr  (level_thr_ff),
         .change_thr (change_thr_ff),
         .hit        (axis_hit[g])
      );
   end

   always_comb begin
      hat_fire    = ~rel_chan_ff[POV_CHAN] | (hat != prev_hat_ff);
      s1_frame_in = s1_frame_ff;
      if (accept) begin
         s1_frame_in.attached = req_tuser;
         s1_frame_in.hit      = {buttons[NUM_BUTTONS-1:0],
                                 hat_fire & hat[HAT_BITS-1],
                                 hat_fire & ~hat[HAT_BITS-1],
                                 axis_hit};
         s1_frame_in.mask     = {en_btn_ff[NUM_BUTTONS-1:0],
                                 en_chan_ff[POV_CHAN],
                                 en_chan_ff[POV_CHAN],
                                 en_chan_ff[NUM_AXES-1:0]};
      end
      s1_valid_in = en1 ? req_tvalid : s1_valid_ff;
      prev_hat_in = update ? hat : prev_hat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_chan_ff    <= ENABLED_CHANNELS_RST;
         rel_chan_ff   <= RELATIVE_CHANNELS_RST;
         en_btn_ff     <= ENABLED_BUTTONS_RST;
         level_thr_ff  <= LEVEL_THRESHOLD_RST;
         change_thr_ff <= CHANGE_THRESHOLD_RST;
         s1_valid_ff   <= 1'b0;
         prev_hat_ff   <= '1;
      end else begin
         en_chan_ff    <= en_chan_in;
         rel_chan_ff   <= rel_chan_in;
         en_btn_ff     <= en_btn_in;
         level_thr_ff  <= level_thr_in;
         change_thr_ff <= change_thr_in;
         s1_valid_ff   <= s1_valid_in;
         prev_hat_ff   <= prev_hat_in;
      end
      s1_frame_ff <= s1_frame_in;
   end

   jed_pack u_pack (
      .clock        (clock),
      .reset        (reset),
      .load         (en2),
      .load_valid   (s1_valid_ff),
      .frame        (s1_frame_ff),
      .valid        (out_valid),
      .events       (events),
      .not_attached (not_attached)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = OUT_DATA_BITS'(events);
   assign rsp_tuser  = not_attached;

   `JED_ASSERT_NEXT(a_detached_keeps_hat, clock, reset, accept && !req_tuser, $stable(prev_hat_ff), "detached request changed previous hat")
   `JED_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp changed while stalled")
   `JED_ASSERT(a_full_stalls, clock, reset, s1_valid_ff && rsp_tvalid && !rsp_tready |-> !req_tready, "req ready while full")

endmodule
